@@ hdl/dmsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double Mersenne string hash: shared definitions
// Constants, sequencer state codes and the control bundle that the sequencer
// hands to the datapath.
// ----------------------------------------------------------------------------
package dmsh_pkg;

  // Mersenne prime 2^61-1 is all ones in 61 bits.
  localparam logic [60:0] MERS61 = '1;

  localparam logic [63:0] ADD_ONE = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] ADD_TWO = 64'h3c6e_f372_fe94_f82a;
  localparam logic [63:0] MIX_A   = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_B   = 64'h94d0_49bb_1331_11eb;

  localparam logic [6:0] SYM_BIAS = 7'd96;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BASE_ONE = 2'd0;
  localparam logic [1:0] CFG_BASE_TWO = 2'd1;
  localparam logic [1:0] CFG_PAD_ONE  = 2'd2;
  localparam logic [1:0] CFG_PAD_TWO  = 2'd3;

  localparam logic [60:0] BASE_ONE_RST = 61'd27;
  localparam logic [60:0] BASE_TWO_RST = 61'd28;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LMUL = 4'd1;
  localparam logic [3:0] ST_LFIX = 4'd2;
  localparam logic [3:0] ST_FPRE = 4'd3;
  localparam logic [3:0] ST_FMUL = 4'd4;
  localparam logic [3:0] ST_FMID = 4'd5;
  localparam logic [3:0] ST_FEND = 4'd6;
  localparam logic [3:0] ST_COMB = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  // Last step of the lane multiply (four products plus one drain step)
  // and of the 64-bit finalizer multiply (three products plus one drain).
  localparam logic [2:0] LMUL_LAST_STEP = 3'd4;
  localparam logic [2:0] FMUL_LAST_STEP = 3'd3;

  // Partial product kinds, low/high halves of the two operands.
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_LH = 2'd1;
  localparam logic [1:0] PP_HL = 2'd2;
  localparam logic [1:0] PP_HH = 2'd3;

  typedef struct packed {
    logic [3:0] st;
    logic [2:0] step;
    logic       lane;  // 0: lane one, 1: lane two
    logic       mix;   // 0: first finalizer constant, 1: second
    logic       load;  // input beat taken this cycle
    logic       emit;  // result moves to the output register this cycle
  } dmsh_ctrl_t;

endpackage

@@ hdl/dmsh_mul32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared 32x32 multiplier
// Unsigned product with a register on its output; one product per cycle.
// ----------------------------------------------------------------------------
module dmsh_mul32 (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

endmodule

@@ hdl/dmsh_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double Mersenne string hash datapath
// Lane accumulators, modular accumulation of partial products, the
// finalizer registers and the final combine, all around one multiplier.
// ----------------------------------------------------------------------------
module dmsh_datapath
  import dmsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dmsh_ctrl_t  ctrl,
  input  logic [6:0]  in_symbol,
  input  logic [60:0] base_one,
  input  logic [60:0] base_two,
  input  logic [63:0] pad_one,
  input  logic [63:0] pad_two,
  output logic [60:0] lane_one,
  output logic [60:0] lane_two,
  output logic [63:0] reduced
);

  logic [60:0] val_r;
  logic [1:0]  kind_r;
  logic [63:0] acc_r;
  logic [60:0] lane1_r, lane2_r;
  logic [63:0] fx_r, m1_r, m2_r, sum_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] pp;

  logic [60:0] lane_cur, base_cur;
  logic [63:0] pad_cur, fadd, kmix;
  logic [61:0] contrib;
  logic [62:0] lane_sum;
  logic [61:0] lane_fold;
  logic [60:0] lane_can;
  logic [63:0] fp_x, fp_s, fp_m;
  logic [60:0] sym_val;

  assign lane_cur = ctrl.lane ? lane2_r : lane1_r;
  assign base_cur = ctrl.lane ? base_two : base_one;
  assign pad_cur  = ctrl.lane ? pad_two : pad_one;
  assign fadd     = ctrl.lane ? ADD_TWO : ADD_ONE;
  assign kmix     = ctrl.mix ? MIX_B : MIX_A;

  // A symbol below the bias wraps modulo 2^61-1.
  assign sym_val = (in_symbol >= SYM_BIAS) ? 61'(in_symbol - SYM_BIAS)
                                           : (MERS61 - 61'(SYM_BIAS) + 61'(in_symbol));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctrl.st == ST_FMUL) begin
      case (ctrl.step[1:0])
        PP_LL: begin
          mul_a = fx_r[31:0];
          mul_b = kmix[31:0];
        end
        PP_LH: begin
          mul_a = fx_r[31:0];
          mul_b = kmix[63:32];
        end
        default: begin
          mul_a = fx_r[63:32];
          mul_b = kmix[31:0];
        end
      endcase
    end else begin
      case (ctrl.step[1:0])
        PP_LL: begin
          mul_a = lane_cur[31:0];
          mul_b = base_cur[31:0];
        end
        PP_LH: begin
          mul_a = lane_cur[31:0];
          mul_b = {3'b000, base_cur[60:32]};
        end
        PP_HL: begin
          mul_a = {3'b000, lane_cur[60:32]};
          mul_b = base_cur[31:0];
        end
        default: begin
          mul_a = {3'b000, lane_cur[60:32]};
          mul_b = {3'b000, base_cur[60:32]};
        end
      endcase
    end
  end

  dmsh_mul32 u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (pp)
  );

  // Each partial product, weighted by 2^0, 2^32 or 2^64, folded to a value
  // congruent modulo 2^61-1 (2^61 is congruent to 1, so 2^64 is 8).
  always_comb begin
    case (kind_r)
      PP_LL:   contrib = {1'b0, pp[60:0]} + {59'd0, pp[63:61]};
      PP_HH:   contrib = {1'b0, pp[57:0], 3'b000};
      default: contrib = {1'b0, pp[28:0], 32'd0} + {30'd0, pp[60:29]};
    endcase
  end

  assign lane_sum  = {1'b0, acc_r[61:0]} + {1'b0, contrib};
  assign lane_fold = {1'b0, lane_sum[60:0]} + {60'd0, lane_sum[62:61]};
  // The folded sum stays below 2^61+3, so one subtraction makes it canonical.
  assign lane_can  = (acc_r[61:0] >= {1'b0, MERS61}) ? 61'(acc_r[61:0] - {1'b0, MERS61})
                                                     : acc_r[60:0];

  assign fp_x = {3'b000, lane_cur} ^ pad_cur;
  assign fp_s = fp_x + fadd;
  assign fp_m = fp_s ^ (fp_s >> 30);

  always_ff @(posedge clk) begin
    kind_r <= ctrl.step[1:0];
    if (ctrl.load) begin
      val_r <= sym_val;
    end
    case (ctrl.st)
      ST_LMUL: begin
        // The accumulator starts from the letter value, so the add is free.
        if (ctrl.step == 3'd0) begin
          acc_r <= {3'b000, val_r};
        end else begin
          acc_r <= {2'b00, lane_fold};
        end
      end
      ST_FMUL: begin
        if (ctrl.step == 3'd1) begin
          acc_r <= pp;
        end else if (ctrl.step != 3'd0) begin
          acc_r <= acc_r + {pp[31:0], 32'd0};
        end
      end
      ST_FPRE: fx_r <= fp_m;
      ST_FMID: fx_r <= acc_r ^ (acc_r >> 27);
      ST_FEND: begin
        if (ctrl.lane) begin
          m2_r <= acc_r ^ (acc_r >> 31);
        end else begin
          m1_r <= acc_r ^ (acc_r >> 31);
        end
      end
      ST_COMB: sum_r <= m1_r + m2_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane1_r <= '0;
      lane2_r <= '0;
    end else if (ctrl.emit) begin
      lane1_r <= '0;
      lane2_r <= '0;
    end else if (ctrl.st == ST_LFIX) begin
      if (ctrl.lane) begin
        lane2_r <= lane_can;
      end else begin
        lane1_r <= lane_can;
      end
    end
  end

  assign lane_one = lane1_r;
  assign lane_two = lane2_r;
  assign reduced  = {sum_r[40:0], sum_r[63:41]} + m1_r;

endmodule

@@ hdl/dmsh_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double Mersenne string hash sequencer
// Steps the shared multiplier through both lane updates and, on the last
// character, through both finalizers and the combine.
// ----------------------------------------------------------------------------
module dmsh_seq
  import dmsh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  input  logic       out_free,
  output logic       in_stall,
  output dmsh_ctrl_t ctrl
);

  logic [3:0] st_r, st_nxt;
  logic [2:0] step_r, step_nxt;
  logic       lane_r, lane_nxt;
  logic       mix_r, mix_nxt;
  logic       last_r, last_nxt;

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    lane_nxt = lane_r;
    mix_nxt  = mix_r;
    last_nxt = last_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt   = ST_LMUL;
          step_nxt = 3'd0;
          lane_nxt = 1'b0;
          last_nxt = in_last;
        end
      end
      ST_LMUL: begin
        if (step_r == LMUL_LAST_STEP) begin
          st_nxt = ST_LFIX;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_LFIX: begin
        if (!lane_r) begin
          lane_nxt = 1'b1;
          step_nxt = 3'd0;
          st_nxt   = ST_LMUL;
        end else if (last_r) begin
          lane_nxt = 1'b0;
          st_nxt   = ST_FPRE;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_FPRE: begin
        st_nxt   = ST_FMUL;
        step_nxt = 3'd0;
        mix_nxt  = 1'b0;
      end
      ST_FMUL: begin
        if (step_r == FMUL_LAST_STEP) begin
          st_nxt = mix_r ? ST_FEND : ST_FMID;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_FMID: begin
        mix_nxt  = 1'b1;
        step_nxt = 3'd0;
        st_nxt   = ST_FMUL;
      end
      ST_FEND: begin
        if (!lane_r) begin
          lane_nxt = 1'b1;
          st_nxt   = ST_FPRE;
        end else begin
          st_nxt = ST_COMB;
        end
      end
      ST_COMB: st_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= '0;
      lane_r <= 1'b0;
      mix_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      lane_r <= lane_nxt;
      mix_r  <= mix_nxt;
      last_r <= last_nxt;
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign ctrl.st   = st_r;
  assign ctrl.step = step_r;
  assign ctrl.lane = lane_r;
  assign ctrl.mix  = mix_r;
  assign ctrl.load = (st_r == ST_IDLE) && in_valid;
  assign ctrl.emit = (st_r == ST_DONE) && out_free;

endmodule

@@ hdl/double_mersenne_string_hash_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double Mersenne string hash unit
// Two polynomial hash lanes modulo 2^61-1 over lowercase letters, with a
// padded and mixed 64-bit digest on the last character of a string.
// ----------------------------------------------------------------------------
// A single 32x32 multiplier does all the multiplies, so the block takes one
// character at a time and holds in_stall high while it works. An ordinary
// character takes four partial products and a reduction step for each lane.
// For a character marked last, after the lane updates each lane runs
// through two 64-bit finalizer multiplies of three partial products
// each, followed by the combine. The result beat sits in an output register,
// and the next string can start while it waits; a second result waits until
// the first one has been taken.
// ----------------------------------------------------------------------------
module double_mersenne_string_hash_unit
  import dmsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_symbol,
  input  logic        in_last,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_reduced_hash,
  output logic [60:0] out_lane_one_hash,
  output logic [60:0] out_lane_two_hash
);

  logic [60:0] base_one_r, base_two_r;
  logic [63:0] pad_one_r, pad_two_r;
  logic        out_valid_r;
  logic [63:0] out_hash_r;
  logic [60:0] out_lane1_r, out_lane2_r;

  logic        out_free;
  dmsh_ctrl_t  ctrl;
  logic [60:0] lane_one, lane_two;
  logic [63:0] reduced;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_one_r <= BASE_ONE_RST;
      base_two_r <= BASE_TWO_RST;
      pad_one_r  <= '0;
      pad_two_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_ONE: base_one_r <= cfg_data[60:0];
        CFG_BASE_TWO: base_two_r <= cfg_data[60:0];
        CFG_PAD_ONE:  pad_one_r  <= cfg_data;
        CFG_PAD_TWO:  pad_two_r  <= cfg_data;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  dmsh_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  dmsh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_symbol (in_symbol),
    .base_one  (base_one_r),
    .base_two  (base_two_r),
    .pad_one   (pad_one_r),
    .pad_two   (pad_two_r),
    .lane_one  (lane_one),
    .lane_two  (lane_two),
    .reduced   (reduced)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_hash_r  <= reduced;
      out_lane1_r <= lane_one;
      out_lane2_r <= lane_two;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reduced_hash  = out_hash_r;
  assign out_lane_one_hash = out_lane1_r;
  assign out_lane_two_hash = out_lane2_r;

endmodule

@@ tb/sv/tb_double_mersenne_string_hash_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double Mersenne string hash unit: testbench
// Streams strings of characters into the unit and checks every digest beat.
// A local model keeps both hash lanes modulo 2^61-1 and predicts the lanes
// and the mixed 64-bit digest. Directed strings cover letter and out-of-range
// symbols and the extreme bases and pads. Random strings then follow under
// several register settings, with random input gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_double_mersenne_string_hash_unit;
  import dmsh_pkg::*;

  localparam logic [60:0] PRIME      = {61{1'b1}};
  localparam logic [63:0] SALT_ONE   = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] SALT_TWO   = 64'h3c6e_f372_fe94_f82a;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
  localparam logic [63:0] ALL_ONES   = {64{1'b1}};
  localparam logic [63:0] TOP_BASE   = 64'h1fff_ffff_ffff_fffe;
  localparam int          IDLE_CYCLES  = 64;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_CHARS = 550;

  typedef struct packed {
    logic [63:0] digest;
    logic [60:0] lane_one;
    logic [60:0] lane_two;
  } hash_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_BASE_ONE;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  in_symbol = 7'd97;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_reduced_hash;
  logic [60:0] out_lane_one_hash;
  logic [60:0] out_lane_two_hash;

  double_mersenne_string_hash_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol         (in_symbol),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reduced_hash  (out_reduced_hash),
    .out_lane_one_hash (out_lane_one_hash),
    .out_lane_two_hash (out_lane_two_hash)
  );

  // Local copy of the hash state and registers.
  logic [60:0] lane_one = '0;
  logic [60:0] lane_two = '0;
  logic [60:0] mult_one = 61'd27;
  logic [60:0] mult_two = 61'd28;
  logic [63:0] mask_one = '0;
  logic [63:0] mask_two = '0;

  hash_beat_t expected_hashes[$];
  int         mismatches = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [60:0] mod_mul(input logic [60:0] a, input logic [60:0] b);
    logic [121:0] prod;
    prod = a * b;
    prod = prod % {61'b0, PRIME};
    return prod[60:0];
  endfunction

  // Symbols below the bias wrap around the modulus.
  function automatic logic [60:0] letter_value(input logic [6:0] sym);
    if (sym >= 7'd96) begin
      return 61'(sym - 7'd96);
    end
    return PRIME - 61'(7'd96 - sym);
  endfunction

  function automatic logic [60:0] step_lane(input logic [60:0] lane, input logic [60:0] base,
                                            input logic [60:0] val);
    logic [61:0] sum;
    sum = mod_mul(lane, base) + val;
    if (sum >= {1'b0, PRIME}) begin
      sum = sum - {1'b0, PRIME};
    end
    return sum[60:0];
  endfunction

  function automatic logic [63:0] mix64(input logic [63:0] word, input logic [63:0] salt);
    logic [63:0] x;
    x = word + salt;
    x = (x ^ (x >> 30)) * MIX_MUL_A;
    x = (x ^ (x >> 27)) * MIX_MUL_B;
    return x ^ (x >> 31);
  endfunction

  function automatic void absorb_char(input logic [6:0] sym, input logic lst);
    logic [60:0] val;
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] sum;
    hash_beat_t  beat;
    val = letter_value(sym);
    lane_one = step_lane(lane_one, mult_one, val);
    lane_two = step_lane(lane_two, mult_two, val);
    if (lst) begin
      m1 = mix64({3'b0, lane_one} ^ mask_one, SALT_ONE);
      m2 = mix64({3'b0, lane_two} ^ mask_two, SALT_TWO);
      sum = m1 + m2;
      beat.digest = {sum[40:0], sum[63:41]} + m1;
      beat.lane_one = lane_one;
      beat.lane_two = lane_two;
      expected_hashes = {expected_hashes, beat};
      lane_one = '0;
      lane_two = '0;
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Result side: stall for a random count after each beat taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      stall_left = quiet ? 0 : $urandom_range(0, 10);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    hash_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, out_reduced_hash);
      end else begin
        want = expected_hashes.pop_front();
        if (out_reduced_hash !== want.digest) begin
          note_mismatch("reduced_hash", want.digest, out_reduced_hash);
        end
        if (out_lane_one_hash !== want.lane_one) begin
          note_mismatch("lane_one_hash", {3'b0, want.lane_one}, {3'b0, out_lane_one_hash});
        end
        if (out_lane_two_hash !== want.lane_two) begin
          note_mismatch("lane_two_hash", {3'b0, want.lane_two}, {3'b0, out_lane_two_hash});
        end
      end
    end
  end

  // Valid stays high into the next beat when no gap is drawn.
  task automatic send_char(input logic [6:0] sym, input logic lst);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_symbol <= 7'($urandom);
      in_last <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_symbol <= sym;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    absorb_char(sym, lst);
  endtask

  task automatic send_word(input string word);
    for (int i = 0; i < word.len(); i++) begin
      send_char(7'(word[i]), i == word.len() - 1);
    end
  endtask

  // A character without last gives no beat, so the unit may still be busy
  // when the queue runs empty; the extra cycles cover that.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] b1, input logic [63:0] b2,
                             input logic [63:0] p1, input logic [63:0] p2);
    logic [1:0]  regs [4];
    logic [63:0] vals [4];
    regs = '{CFG_BASE_ONE, CFG_BASE_TWO, CFG_PAD_ONE, CFG_PAD_TWO};
    vals = '{b1, b2, p1, p2};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    mult_one = b1[60:0];
    mult_two = b2[60:0];
    mask_one = p1;
    mask_two = p2;
  endtask

  function automatic logic [63:0] pick_base();
    case ($urandom_range(0, 5))
      0: return 64'd27;
      1: return TOP_BASE;
      2: return ALL_ONES;
      3: return 64'd0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_pad();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_default_config();
    send_word("a");
    send_word("z");
    send_word("abc");
    send_word("zzzz");
  endtask

  task automatic test_symbol_extremes();
    load_config(64'd27, 64'd28, ALL_ONES, 64'h5555_5555_5555_5555);
    send_char(7'd0, 1'b0);
    send_char(7'd127, 1'b0);
    send_char(7'd95, 1'b0);
    send_char(7'd96, 1'b0);
    send_char(7'd123, 1'b1);
    send_char(7'd0, 1'b1);
  endtask

  task automatic test_base_extremes();
    // An all-ones base reduces to the modulus and acts as zero.
    load_config(ALL_ONES, ALL_ONES ^ 64'h1, 64'd0, ALL_ONES);
    send_word("zzq");
    load_config(64'd27, 64'd27, 64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef);
    send_word("hello");
    load_config(64'd0, TOP_BASE, ALL_ONES, 64'd0);
    send_word("yz");
  endtask

  task automatic test_random_strings();
    int sent;
    int len;
    int phase_end;
    logic [6:0] sym;
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      load_config(pick_base(), pick_base(), pick_pad(), pick_pad());
      phase_end = sent + 110;
      while (sent < phase_end) begin
        if ($urandom_range(0, 14) == 0) begin
          quiet = ~quiet;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          sym = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(97, 122));
          send_char(sym, i == len - 1);
        end
        sent += len;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_symbol_extremes();
    test_base_extremes();
    test_random_strings();
    settle();
    if (mismatches == 0 && expected_hashes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ double_mersenne_string_hash_unit.f @@
hdl/dmsh_pkg.sv
hdl/dmsh_mul32.sv
hdl/dmsh_datapath.sv
hdl/dmsh_seq.sv
hdl/double_mersenne_string_hash_unit.sv
tb/sv/tb_double_mersenne_string_hash_unit.sv
